[src/rtf_subset_to_text_defines.svh]
// Assertion macros for the RTF subset decoder.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef RTF_SUBSET_TO_TEXT_DEFINES_SVH
`define RTF_SUBSET_TO_TEXT_DEFINES_SVH

// Check a consequence in the same cycle.
`define RTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the following cycle.
`define RTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rtf_pkg.sv]
// Shared types and constants for the RTF subset decoder.
// No dependencies; used by every module of the block.
package rtf_pkg;

  // Result kind codes
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Most results one input byte can cause
  localparam int MaxResults = 3;

  // Default number of result groups held between parser and output
  localparam int FifoDepthDefault = 4;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } rtf_res_t;

  // All results caused by one input byte, oldest in entry 0
  typedef struct packed {
    logic [1:0]                 cnt;
    rtf_res_t [MaxResults-1:0]  res;
  } rtf_bundle_t;

endpackage

[src/rtf_front.sv]
// Parser front end: holds the parse state and turns one RTF byte into a
// group of up to three results. Depends on rtf_pkg.
module rtf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         in_byte,
  input  logic               final_byte,
  input  logic               accept,
  output rtf_pkg::rtf_bundle_t bundle
);
  import rtf_pkg::*;

  typedef enum logic [2:0] {
    MODE_TEXT  = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX1  = 3'd2,
    MODE_HEX2  = 3'd3,
    MODE_WORD  = 3'd4,
    MODE_PARAM = 3'd5
  } mode_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       bad;
    logic       emit;
    logic [7:0] data;
  } word_res_t;

  // Known words, first letter in the low byte
  localparam logic [31:0] W_PAR  = 32'h0072_6170;
  localparam logic [31:0] W_TAB  = 32'h0062_6174;
  localparam logic [31:0] W_RTF  = 32'h0066_7472;
  localparam logic [31:0] W_ANSI = 32'h6973_6e61;
  localparam logic [31:0] W_DEFF = 32'h6666_6564;
  localparam logic [31:0] W_PARD = 32'h6472_6170;
  localparam logic [7:0]  CH_CR  = 8'h0d;
  localparam logic [7:0]  CH_TAB = 8'h09;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_param(input logic [7:0] c);
    return c == "-" || (c >= "0" && c <= "9");
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= "0" && c <= "9") begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  function automatic word_res_t word_class(input logic [31:0] w, input logic [2:0] n);
    word_res_t r;
    r = '0;
    if (n == 3'd3 && w == W_PAR) begin
      r.emit = 1'b1;
      r.data = CH_CR;
    end else if (n == 3'd3 && w == W_TAB) begin
      r.emit = 1'b1;
      r.data = CH_TAB;
    end else if ((n == 3'd3 && w == W_RTF) || (n == 3'd4 && w == W_ANSI) ||
                 (n == 3'd4 && w == W_DEFF) || (n == 3'd4 && w == W_PARD)) begin
      r.bad = 1'b0;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  mode_t       mode, mode_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [31:0] word_letters, word_letters_next;
  logic [2:0]  word_count, word_count_next;
  logic        error_seen, error_seen_next;
  logic [1:0]  n;
  hex_t        hx;
  word_res_t   wr;

  // Decode one byte and collect its results in order
  always_comb begin
    mode_next         = mode;
    high_nibble_next  = high_nibble;
    word_letters_next = word_letters;
    word_count_next   = word_count;
    error_seen_next   = error_seen;
    bundle            = '0;
    n                 = '0;
    hx                = hex_digit(in_byte);
    wr                = word_class(word_letters, word_count);

    if (!error_seen) begin
      unique case (mode)
        MODE_ESC: begin
          if (in_byte == "\\" || in_byte == "{" || in_byte == "}") begin
            bundle.res[n] = '{data: in_byte, kind: KIND_TEXT};
            n             = n + 2'd1;
            mode_next     = MODE_TEXT;
          end else if (in_byte == "'") begin
            mode_next = MODE_HEX1;
          end else if (is_letter(in_byte)) begin
            word_letters_next = {24'd0, in_byte};
            word_count_next   = 3'd1;
            mode_next         = MODE_WORD;
          end else begin
            error_seen_next = 1'b1;
            mode_next       = MODE_TEXT;
          end
        end
        MODE_HEX1: begin
          if (hx.ok) begin
            high_nibble_next = hx.val;
            mode_next        = MODE_HEX2;
          end else begin
            error_seen_next = 1'b1;
            mode_next       = MODE_TEXT;
          end
        end
        MODE_HEX2: begin
          if (hx.ok) begin
            bundle.res[n] = '{data: {high_nibble, hx.val}, kind: KIND_TEXT};
            n             = n + 2'd1;
            mode_next     = MODE_TEXT;
          end else begin
            error_seen_next = 1'b1;
            mode_next       = MODE_TEXT;
          end
        end
        MODE_WORD: begin
          if (is_letter(in_byte)) begin
            if (word_count < 3'd4) begin
              word_letters_next[{word_count[1:0], 3'b000} +: 8] = in_byte;
            end
            if (word_count < 3'd5) begin
              word_count_next = word_count + 3'd1;
            end
          end else begin
            // Close the word, then handle the ending byte
            if (wr.bad) begin
              error_seen_next = 1'b1;
              mode_next       = MODE_TEXT;
            end else begin
              if (wr.emit) begin
                bundle.res[n] = '{data: wr.data, kind: KIND_TEXT};
                n             = n + 2'd1;
              end
              if (is_param(in_byte)) begin
                mode_next = MODE_PARAM;
              end else if (in_byte == " " || in_byte == "{" || in_byte == "}") begin
                mode_next = MODE_TEXT;
              end else if (in_byte == "\\") begin
                mode_next = MODE_ESC;
              end else begin
                mode_next     = MODE_TEXT;
                bundle.res[n] = '{data: in_byte, kind: KIND_TEXT};
                n             = n + 2'd1;
              end
            end
          end
        end
        MODE_PARAM: begin
          if (!is_param(in_byte)) begin
            if (in_byte == " " || in_byte == "{" || in_byte == "}") begin
              mode_next = MODE_TEXT;
            end else if (in_byte == "\\") begin
              mode_next = MODE_ESC;
            end else begin
              mode_next     = MODE_TEXT;
              bundle.res[n] = '{data: in_byte, kind: KIND_TEXT};
              n             = n + 2'd1;
            end
          end
        end
        default: begin
          if (in_byte == "\\") begin
            mode_next = MODE_ESC;
          end else if (in_byte == "{" || in_byte == "}") begin
            mode_next = MODE_TEXT;
          end else begin
            mode_next     = MODE_TEXT;
            bundle.res[n] = '{data: in_byte, kind: KIND_TEXT};
            n             = n + 2'd1;
          end
        end
      endcase
    end

    // Close the document: finish an open word, flag an open escape
    if (final_byte) begin
      if (!error_seen_next) begin
        if (mode_next == MODE_WORD) begin
          wr = word_class(word_letters_next, word_count_next);
          if (wr.bad) begin
            error_seen_next = 1'b1;
          end else if (wr.emit) begin
            bundle.res[n] = '{data: wr.data, kind: KIND_TEXT};
            n             = n + 2'd1;
          end
        end else if (mode_next == MODE_ESC || mode_next == MODE_HEX1 ||
                     mode_next == MODE_HEX2) begin
          error_seen_next = 1'b1;
        end
      end
      bundle.res[n] = '{data: 8'd0, kind: error_seen_next ? KIND_ERR : KIND_OK};
      n             = n + 2'd1;
      mode_next         = MODE_TEXT;
      high_nibble_next  = '0;
      word_letters_next = '0;
      word_count_next   = '0;
      error_seen_next   = 1'b0;
    end

    bundle.cnt = n;
  end

  // Advance parse state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_TEXT;
      high_nibble  <= '0;
      word_letters <= '0;
      word_count   <= '0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      high_nibble  <= high_nibble_next;
      word_letters <= word_letters_next;
      word_count   <= word_count_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

[src/rtf_fifo.sv]
// Short queue of result groups between the parser and the output stage.
// Depends on rtf_pkg for the group type.
module rtf_fifo #(
  parameter int Depth = rtf_pkg::FifoDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  rtf_pkg::rtf_bundle_t wr_data,
  input  logic                 rd_en,
  output rtf_pkg::rtf_bundle_t rd_data,
  output logic                 full,
  output logic                 empty
);
  import rtf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rtf_bundle_t     mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store incoming groups
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/rtf_back.sv]
// Output stage: hands out the results of the oldest queued group one per
// transfer and marks the last one. Depends on rtf_pkg.
module rtf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rtf_pkg::rtf_bundle_t head,
  input  logic                 head_valid,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic [1:0]           kind,
  output logic                 run_end,
  output logic                 deq
);
  import rtf_pkg::*;

  logic [1:0] idx;
  logic       last;
  rtf_res_t   cur;

  assign cur      = head.res[idx];
  assign last     = (idx == head.cnt - 2'd1);
  assign empty    = !head_valid;
  assign out_byte = cur.data;
  assign kind     = cur.kind;
  assign run_end  = last;
  assign deq      = pop && head_valid && last;

  // Step through the group; drop it after its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && head_valid) begin
      idx <= last ? '0 : idx + 2'd1;
    end
  end

endmodule

[src/rtf_subset_to_text.sv]
// Top level of the RTF subset decoder: parser, group queue, output stage.
// Depends on rtf_pkg, rtf_front, rtf_fifo, rtf_back and the defines header.
`include "rtf_subset_to_text_defines.svh"

// Accepts one RTF byte per cycle while full is low and delivers decoded text
// bytes and one end-of-document status (kind 1 ok, kind 2 error) per
// document; run_end marks the last result of each input byte. The parser
// writes each byte's results as one group into a queue of FifoDepth groups;
// full is high while that queue is full, and the output side drains one
// result per pop, so a byte that yields two or three results holds the
// output for as many pops. Bytes that yield nothing are not queued.
// No start-up pass is needed after reset.
module rtf_subset_to_text #(
  parameter int FifoDepth = rtf_pkg::FifoDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       run_end,
  output logic       empty,
  input  logic       pop
);
  import rtf_pkg::*;

  rtf_bundle_t bundle, head;
  logic        accept, q_empty, deq;

  assign accept = push && !full;

  // Parse one byte per transfer
  rtf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .accept     (accept),
    .bundle     (bundle)
  );

  // Queue non-empty result groups
  rtf_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && bundle.cnt != 2'd0),
    .wr_data (bundle),
    .rd_en   (deq),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  // Hand out results one at a time
  rtf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .kind       (kind),
    .run_end    (run_end),
    .deq        (deq)
  );

  `RTF_ASSERT_NOW(a_status_last, (!empty && kind != KIND_TEXT), run_end, "status not last")
  `RTF_ASSERT_NEXT(a_group_holds, (pop && !empty && !run_end), !empty, "group lost mid-way")
  `RTF_ASSERT_NEXT(a_final_queued, (push && !full && final_byte), !empty, "status not queued")
  `RTF_ASSERT_NOW(a_kind_code, !empty, (kind == KIND_TEXT || kind == KIND_OK ||
                  kind == KIND_ERR), "bad result kind")

endmodule

[tb/sv/rtf_subset_to_text_tb.sv]
`timescale 1ns / 100ps
// Testbench for rtf_subset_to_text: directed and random RTF documents driven through
// the push/full side, results checked on the pop/empty side by a behavioral decoder.
// Depends on rtf_pkg and the rtf_subset_to_text RTL.
module rtf_subset_to_text_tb;
  import rtf_pkg::*;

  localparam int LimitCycles   = 200000;
  localparam int RandomBytes   = 130;
  localparam int HoldOffCycles = 250;
  localparam int DrainCycles   = 20;

  // Parser modes of the behavioral decoder
  typedef enum logic [2:0] {
    PS_TEXT, PS_ESC, PS_HEX1, PS_HEX2, PS_WORD, PS_PARAM
  } parse_st_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } rtf_in_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } text_out_t;

  logic       clk;
  logic       rst;
  logic [7:0] in_byte;
  logic       final_byte;
  logic       push;
  logic       full;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_end;
  logic       empty;
  logic       pop;

  rtf_subset_to_text u_top (.*);

  rtf_in_t   rtf_stream[$];
  text_out_t expected_text[$];
  text_out_t byte_results[$];

  // Decoder state
  parse_st_t   dec_mode;
  logic [3:0]  dec_nibble;
  logic [31:0] dec_letters;
  logic [2:0]  dec_count;
  logic        dec_err;

  int          mismatch_cnt;
  int          sent_cnt;
  int          cycle_cnt;
  int          burst_left;
  int          gap_left;
  logic        hold_off;
  logic [15:0] rcv_tick;

  string hex_chars = "0123456789abcdefABCDEF";
  string param_chars = "-0123456789";
  string known_words[6] = '{"par", "tab", "rtf", "ansi", "deff", "pard"};

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------------
  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c == "-" || (c >= "0" && c <= "9");
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function void clear_decoder();
    dec_mode    = PS_TEXT;
    dec_nibble  = '0;
    dec_letters = '0;
    dec_count   = '0;
    dec_err     = 1'b0;
  endfunction

  function void add_result(logic [7:0] d, logic [1:0] k);
    text_out_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    byte_results.push_back(r);
  endfunction

  // Drop text once the document has gone bad
  function void add_text(logic [7:0] d);
    if (!dec_err) add_result(d, KIND_TEXT);
  endfunction

  function void flag_error();
    dec_err  = 1'b1;
    dec_mode = PS_TEXT;
  endfunction

  // Letters are shifted in, so the first letter ends up in the high byte
  function void close_word();
    if (dec_count == 3 && dec_letters == {8'h00, "par"}) add_text(8'h0D);
    else if (dec_count == 3 && dec_letters == {8'h00, "tab"}) add_text(8'h09);
    else if ((dec_count == 3 && dec_letters == {8'h00, "rtf"}) ||
             (dec_count == 4 && dec_letters == "ansi") ||
             (dec_count == 4 && dec_letters == "deff") ||
             (dec_count == 4 && dec_letters == "pard")) begin
      // ignored word
    end else begin
      flag_error();
    end
  endfunction

  function void read_text(logic [7:0] c);
    if (c == "\\") dec_mode = PS_ESC;
    else if (c == "{" || c == "}") dec_mode = PS_TEXT;
    else begin
      dec_mode = PS_TEXT;
      add_text(c);
    end
  endfunction

  // Skip one space after a word or parameter, else reread as text
  function void after_word(logic [7:0] c);
    if (c == " ") dec_mode = PS_TEXT;
    else read_text(c);
  endfunction

  function void decode_rtf_byte(logic [7:0] c, logic fin);
    int hv;
    byte_results.delete();
    if (!dec_err) begin
      case (dec_mode)
        PS_ESC: begin
          if (c == "\\" || c == "{" || c == "}") begin
            add_text(c);
            dec_mode = PS_TEXT;
          end else if (c == "'") begin
            dec_mode = PS_HEX1;
          end else if (is_alpha(c)) begin
            dec_letters = {24'h0, c};
            dec_count   = 3'd1;
            dec_mode    = PS_WORD;
          end else begin
            flag_error();
          end
        end
        PS_HEX1: begin
          hv = hex_val(c);
          if (hv < 0) flag_error();
          else begin
            dec_nibble = hv[3:0];
            dec_mode   = PS_HEX2;
          end
        end
        PS_HEX2: begin
          hv = hex_val(c);
          if (hv < 0) flag_error();
          else begin
            add_text({dec_nibble, hv[3:0]});
            dec_mode = PS_TEXT;
          end
        end
        PS_WORD: begin
          if (is_alpha(c)) begin
            if (dec_count < 4) dec_letters = {dec_letters[23:0], c};
            if (dec_count < 5) dec_count++;
          end else begin
            close_word();
            if (!dec_err) begin
              if (is_num(c)) dec_mode = PS_PARAM;
              else after_word(c);
            end
          end
        end
        PS_PARAM: begin
          if (!is_num(c)) after_word(c);
        end
        default: read_text(c);
      endcase
    end
    // Close the document: finish an open word, fail an open escape
    if (fin) begin
      if (!dec_err) begin
        if (dec_mode == PS_WORD) close_word();
        else if (dec_mode inside {PS_ESC, PS_HEX1, PS_HEX2}) flag_error();
      end
      add_result(8'h00, dec_err ? KIND_ERR : KIND_OK);
      clear_decoder();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) expected_text.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function void put_byte(logic [7:0] b, logic f);
    rtf_in_t it;
    it.data = b;
    it.fin  = f;
    rtf_stream.push_back(it);
  endfunction

  function void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endfunction

  // Mark the last queued byte as the end of the document
  function void close_doc();
    rtf_stream[rtf_stream.size() - 1].fin = 1'b1;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a") + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 3) == 0) c = c - 8'h20;
    return c;
  endfunction

  function void add_random_doc();
    int ntok;
    int sel;
    int len;
    ntok = $urandom_range(1, 12);
    for (int i = 0; i < ntok; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        // plain text byte of any value
        put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 40) begin
        put_byte("\\", 1'b0);
        case ($urandom_range(0, 2))
          0:       put_byte("\\", 1'b0);
          1:       put_byte("{", 1'b0);
          default: put_byte("}", 1'b0);
        endcase
      end else if (sel < 55) begin
        put_str("\\'");
        put_byte(hex_chars[$urandom_range(0, 21)], 1'b0);
        put_byte(hex_chars[$urandom_range(0, 21)], 1'b0);
      end else if (sel < 78) begin
        // known word, optional parameter, optional space
        put_byte("\\", 1'b0);
        put_str(known_words[$urandom_range(0, 5)]);
        len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        for (int k = 0; k < len; k++) put_byte(param_chars[$urandom_range(0, 10)], 1'b0);
        if ($urandom_range(0, 2) != 0) put_byte(" ", 1'b0);
      end else if (sel < 86) begin
        put_byte(($urandom_range(0, 1) == 0) ? 8'("{") : 8'("}"), 1'b0);
      end else if (sel < 90) begin
        // word of random letters, mostly unknown
        put_byte("\\", 1'b0);
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) put_byte(rand_letter(), 1'b0);
        put_byte(" ", 1'b0);
      end else if (sel < 93) begin
        put_byte("\\", 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 96) begin
        put_str("\\'");
        if ($urandom_range(0, 1) == 0) put_byte(hex_chars[$urandom_range(0, 21)], 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // noise, now and then cutting the document short
        put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
    // Leave an escape open at the end now and then
    case ($urandom_range(0, 11))
      0:       put_byte("\\", 1'b0);
      1:       put_str("\\'");
      default: ;
    endcase
    close_doc();
  endfunction

  function void build_stimulus();
    int dir_cnt;
    // Escapes, hex extremes, braces, raw extremes, parameter; word ended by a copied byte
    put_str("\\'00\\'fF\\{\\}\\\\{");
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_str("}\\rtf-1 \\par!");
    close_doc();
    // Ignored words, word ended by a backslash, word still open at the end
    put_str("\\ansi\\deff0\\pard \\tab");
    close_doc();
    // Upper-case word, then bytes after the error
    put_str("\\PAR x");
    close_doc();
    // Word longer than four letters
    put_str("\\pardy");
    close_doc();
    // Empty word
    put_str("\\9a");
    close_doc();
    // Bad hex digit
    put_str("\\'G1");
    close_doc();
    // Hex escape, then a bare escape, cut off at the end
    put_str("\\'4");
    close_doc();
    put_str("\\");
    close_doc();
    dir_cnt = rtf_stream.size();
    while (rtf_stream.size() < dir_cnt + RandomBytes) add_random_doc();
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, run control
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : main_p
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    in_byte      = '0;
    final_byte   = 1'b0;
    mismatch_cnt = 0;
    sent_cnt     = 0;
    rcv_tick     = '0;
    clear_decoder();
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Wait for every byte to transfer, then for every result
    while (rtf_stream.size() != 0 || push) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) $display("rtf_subset_to_text_tb passed");
    else $display("rtf_subset_to_text_tb failed");
    $finish;
  end

  initial begin : watchdog_p
    cycle_cnt = 0;
    while (cycle_cnt < LimitCycles) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("rtf_subset_to_text_tb failed");
    $finish;
  end

  // Hold the receiver off long enough for the block to fill and stall input
  initial begin : hold_p
    hold_off = 1'b0;
    while (sent_cnt < 30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_p
    rtf_in_t sent;
    logic    offer;
    if (rst) begin
      push       <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // Predict the results of a byte as it transfers
      if (push && !full) begin
        sent = rtf_stream.pop_front();
        decode_rtf_byte(sent.data, sent.fin);
        sent_cnt++;
        if (burst_left > 0) burst_left--;
      end
      offer = 1'b0;
      if (push && full) begin
        offer = 1'b1;
      end else if (rtf_stream.size() > 0) begin
        if (hold_off) begin
          offer = 1'b1;
        end else begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
          if (gap_left > 0) gap_left--;
          else offer = 1'b1;
        end
      end
      push <= offer;
      if (offer) begin
        in_byte    <= rtf_stream[0].data;
        final_byte <= rtf_stream[0].fin;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each transfer, stall on a rotating pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_p
    text_out_t want;
    logic      want_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h kind %0d run_end %0b",
                                    out_byte, kind, run_end));
        end else begin
          want = expected_text.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
          if (run_end !== want.last)
            report_mismatch($sformatf("run_end %0b, want %0b", run_end, want.last));
        end
      end
      rcv_tick = rcv_tick + 16'd1;
      case (rcv_tick[8:7])
        2'd0:    want_pop = 1'b1;
        2'd1:    want_pop = ($urandom_range(0, 1) == 0);
        2'd2:    want_pop = ($urandom_range(0, 3) == 0);
        default: want_pop = (rcv_tick[2:0] != 3'd0);
      endcase
      pop <= want_pop && !hold_off;
    end
  end

endmodule
